### sv/gld_pkg.sv
// gld_pkg: shared types and constants of the gif lzw decoder
// depends on nothing; used by the core and the checker by scoped names
package gld_pkg;

  localparam int MAX_CODE_BITS  = 12;
  localparam int DICT_AW        = 12;
  localparam int DICT_DEPTH     = 4096;
  localparam int STACK_AW       = 12;
  localparam int STACK_DEPTH    = 4096;
  localparam int MAX_LINE_WIDTH = 4096;
  localparam int LW_W           = 13;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_X_SKIP     = 2'd1;
  localparam logic [1:0] REG_Y_SKIP     = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SIZE  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_BUSY  = 2'd3
  } err_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel;
    logic        row_end;
    logic        byte_ready;
    logic        image_done;
    err_t        error_code;
    logic [15:0] bad_codes;
  } out_item_t;

endpackage

### sv/gld_ram.sv
// gld_ram: simple dual-port ram, one write port, one registered read port
// depends on nothing
module gld_ram #(
  parameter int AW = 12,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/gif_lzw_decoder_core.sv
// gif_lzw_decoder_core: gif lzw decoder top level with dictionary and pixel stack
// depends on gld_pkg and gld_ram
//
// usage: the input channel carries one beat per request: a stream byte
// (req_type 0, start_image marks the minimum code size byte) or a drain tick
// (req_type 1) that pops one pixel from the stack. every input beat yields
// exactly one result beat on the output channel, in order.
// one item is processed at a time; in_stall is high while an item is in work.
// a drain tick that pops a pixel passes the pop state and then decoding; a data
// byte goes straight to decoding; any other beat goes straight to the output
// state. decoding a code unpacks it, reads one dictionary ram entry per link
// of its prefix chain and then writes the new dictionary entry; the walk is
// bounded by the 4096 entry dictionary.
// the finished result sits in an output register; the next input beat is
// taken while it waits, and its own result waits until out_stall drops.
// cfg writes are always taken (cfg_ready is high) and are meant for idle time.
// reset (synchronous, rst_n low) clears all control state; the dictionary and
// stack rams are not cleared and need no clearing pass.
module gif_lzw_decoder_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gld_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gld_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_POP, S_ADV, S_WALK, S_TAIL, S_OUT} state_t;
  typedef enum logic [1:0] {PH_WAIT, PH_LENGTH, PH_DATA, PH_DONE} phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [12:0] sp_r, sp_nxt;
  logic [23:0] buf_r, buf_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic [12:0] ns_r, ns_nxt;
  logic [12:0] lim_r, lim_nxt;
  logic [11:0] prev_r, prev_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [12:0] col_r, col_nxt;
  logic [7:0]  xsc_r, xsc_nxt;
  logic [7:0]  ysc_r, ysc_nxt;
  logic [15:0] bad_r, bad_nxt;
  logic [3:0]  root_r, root_nxt;
  logic        aclr_r, aclr_nxt;
  logic [11:0] cur_r, cur_nxt;
  logic [11:0] c_r, c_nxt;
  logic [12:0] guard_r, guard_nxt;
  logic [12:0] lw_r, lw_nxt;
  logic [7:0]  xskip_r, xskip_nxt;
  logic [7:0]  yskip_r, yskip_nxt;
  logic        rv_r, rv_nxt;
  logic [7:0]  rpix_r, rpix_nxt;
  logic        rend_r, rend_nxt;
  gld_pkg::err_t rerr_r, rerr_nxt;
  logic        out_valid_r, out_valid_nxt;
  gld_pkg::out_item_t out_data_r, out_data_nxt;

  logic        push_en;
  logic [7:0]  push_data;
  logic [19:0] dict_wdata, dict_rdata;
  logic [11:0] dict_waddr, dict_raddr;
  logic        dict_we;
  logic [11:0] stk_raddr;
  logic [7:0]  stk_rdata;
  logic        stk_we;

  logic [12:0] effw, clr13, end13, newc13, code13, ns_add, col_t;
  logic [11:0] code, cval, curv, nxt_link;
  logic        keep_row, keep_x, ready;

  gld_ram #(.AW(gld_pkg::DICT_AW), .DW(20)) u_dict (
    .clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(dict_wdata),
    .raddr(dict_raddr), .rdata(dict_rdata)
  );

  gld_ram #(.AW(gld_pkg::STACK_AW), .DW(8)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp_r[gld_pkg::STACK_AW-1:0]), .wdata(push_data),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign stk_we    = push_en && (sp_r < 13'(gld_pkg::STACK_DEPTH));
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    effw = lw_r;
    if (lw_r == 13'd0) begin
      effw = 13'd1;
    end else if (lw_r > 13'(gld_pkg::MAX_LINE_WIDTH)) begin
      effw = 13'(gld_pkg::MAX_LINE_WIDTH);
    end
    clr13  = 13'd1 << root_r;
    end13  = clr13 + 13'd1;
    newc13 = clr13 + 13'd2;
    code   = buf_r[11:0] & ~(12'hFFF << cw_r);
    code13 = {1'b0, code};
  end

  always_comb begin
    state_nxt = state_r;   phase_nxt = phase_r;  sp_nxt = sp_r;
    buf_nxt = buf_r;       bits_nxt = bits_r;    cw_nxt = cw_r;
    ns_nxt = ns_r;         lim_nxt = lim_r;      prev_nxt = prev_r;
    first_nxt = first_r;   sub_nxt = sub_r;      col_nxt = col_r;
    xsc_nxt = xsc_r;       ysc_nxt = ysc_r;      bad_nxt = bad_r;
    root_nxt = root_r;     aclr_nxt = aclr_r;    cur_nxt = cur_r;
    c_nxt = c_r;           guard_nxt = guard_r;  lw_nxt = lw_r;
    xskip_nxt = xskip_r;   yskip_nxt = yskip_r;
    rv_nxt = rv_r;         rpix_nxt = rpix_r;    rend_nxt = rend_r;
    rerr_nxt = rerr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    push_en = 1'b0;        push_data = 8'd0;
    dict_we = 1'b0;        dict_waddr = ns_r[11:0];
    dict_wdata = {prev_r, cur_r[7:0]};
    dict_raddr = cur_r;    stk_raddr = 12'(sp_r - 13'd1);
    keep_row = 1'b0;       keep_x = 1'b0;        col_t = col_r;
    cval = code;           curv = code;          nxt_link = dict_rdata[19:8];
    ns_add = ns_r;         ready = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        gld_pkg::REG_LINE_WIDTH: lw_nxt = cfg_data;
        gld_pkg::REG_X_SKIP:     xskip_nxt = cfg_data[7:0];
        gld_pkg::REG_Y_SKIP:     yskip_nxt = cfg_data[7:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rv_nxt = 1'b0; rpix_nxt = 8'd0; rend_nxt = 1'b0; rerr_nxt = gld_pkg::ERR_NONE;
          state_nxt = S_OUT;
          if (in_data.req_type == gld_pkg::REQ_DRAIN) begin
            if (sp_r != 13'd0) begin
              sp_nxt = sp_r - 13'd1;
              state_nxt = S_POP;
            end
          end else if (in_data.start_image) begin
            sp_nxt = 13'd0; buf_nxt = 24'd0; bits_nxt = 5'd0; sub_nxt = 8'd0;
            aclr_nxt = 1'b0;
            if (in_data.in_byte < 8'd2 || in_data.in_byte > 8'd9) begin
              rerr_nxt = gld_pkg::ERR_SIZE;
              phase_nxt = PH_WAIT;
            end else begin
              root_nxt = in_data.in_byte[3:0];
              cw_nxt = in_data.in_byte[3:0] + 4'd1;
              lim_nxt = 13'd1 << (in_data.in_byte[3:0] + 4'd1);
              ns_nxt = (13'd1 << in_data.in_byte[3:0]) + 13'd2;
              prev_nxt = 12'd0; first_nxt = 8'd0;
              col_nxt = effw; xsc_nxt = 8'd0; ysc_nxt = 8'd0;
              phase_nxt = PH_LENGTH;
            end
          end else if (phase_r == PH_LENGTH || phase_r == PH_DATA) begin
            if (sp_r != 13'd0 || bits_r >= 5'(cw_r)) begin
              rerr_nxt = gld_pkg::ERR_BUSY;
            end else if (phase_r == PH_LENGTH) begin
              if (in_data.in_byte == 8'd0) begin
                rerr_nxt = gld_pkg::ERR_EMPTY;
              end else begin
                sub_nxt = in_data.in_byte;
                phase_nxt = PH_DATA;
              end
            end else begin
              buf_nxt = buf_r | (24'(in_data.in_byte) << bits_r);
              bits_nxt = bits_r + 5'd8;
              if (sub_r != 8'd0) begin
                sub_nxt = sub_r - 8'd1;
              end
              if (sub_r <= 8'd1) begin
                phase_nxt = PH_LENGTH;
              end
              state_nxt = S_ADV;
            end
          end
        end
      end
      S_POP: begin
        keep_row = (ysc_r == 8'd0);
        keep_x = (xsc_r == 8'd0);
        xsc_nxt = keep_x ? xskip_r : xsc_r - 8'd1;
        if (keep_row && keep_x) begin
          rv_nxt = 1'b1;
          rpix_nxt = stk_rdata;
        end
        col_t = ((col_r == 13'd0) ? 13'd1 : col_r) - 13'd1;
        col_nxt = col_t;
        if (col_t == 13'd0) begin
          if (keep_row) begin
            rend_nxt = 1'b1;
            ysc_nxt = yskip_r;
          end else begin
            ysc_nxt = ysc_r - 8'd1;
          end
          col_nxt = effw;
          xsc_nxt = 8'd0;
        end
        state_nxt = S_ADV;
      end
      S_ADV: begin
        if ((phase_r == PH_LENGTH || phase_r == PH_DATA) && sp_r == 13'd0 &&
            cw_r >= 4'd1 && cw_r <= 4'(gld_pkg::MAX_CODE_BITS) &&
            bits_r >= 5'(cw_r)) begin
          buf_nxt = buf_r >> cw_r;
          bits_nxt = bits_r - 5'(cw_r);
          if (code13 == end13) begin
            phase_nxt = PH_DONE;
          end else if (code13 == clr13) begin
            cw_nxt = root_r + 4'd1;
            ns_nxt = newc13;
            lim_nxt = 13'd1 << (root_r + 4'd1);
            aclr_nxt = 1'b1;
          end else if (aclr_r) begin
            aclr_nxt = 1'b0;
            cval = (code13 >= ns_r) ? 12'd0 : code;
            prev_nxt = cval;
            first_nxt = cval[7:0];
            push_en = 1'b1;
            push_data = cval[7:0];
          end else begin
            if (code13 >= ns_r) begin
              if (code13 > ns_r) begin
                if (bad_r != 16'hFFFF) begin
                  bad_nxt = bad_r + 16'd1;
                end
                cval = ns_r[11:0];
              end
              curv = prev_r;
              push_en = 1'b1;
              push_data = first_r;
            end
            c_nxt = cval;
            cur_nxt = curv;
            guard_nxt = 13'd0;
            dict_raddr = curv;
            state_nxt = ({1'b0, curv} >= newc13) ? S_WALK : S_TAIL;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        push_en = 1'b1;
        push_data = dict_rdata[7:0];
        guard_nxt = guard_r + 13'd1;
        cur_nxt = nxt_link;
        dict_raddr = nxt_link;
        if (!({1'b0, nxt_link} >= newc13 && guard_nxt < 13'(gld_pkg::DICT_DEPTH))) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        push_en = 1'b1;
        push_data = cur_r[7:0];
        if (ns_r < lim_r && ns_r < 13'(gld_pkg::DICT_DEPTH)) begin
          dict_we = 1'b1;
          first_nxt = cur_r[7:0];
          ns_add = ns_r + 13'd1;
          prev_nxt = c_r;
        end
        ns_nxt = ns_add;
        if (ns_add >= lim_r && cw_r < 4'(gld_pkg::MAX_CODE_BITS)) begin
          lim_nxt = lim_r << 1;
          cw_nxt = cw_r + 4'd1;
        end
        state_nxt = S_ADV;
      end
      S_OUT: begin
        if (phase_r == PH_WAIT) begin
          ready = 1'b1;
        end else if (phase_r == PH_DONE) begin
          ready = 1'b0;
        end else begin
          ready = (sp_r == 13'd0) && (bits_r < 5'(cw_r));
        end
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.pixel_valid = rv_r;
          out_data_nxt.pixel       = rpix_r;
          out_data_nxt.row_end     = rend_r;
          out_data_nxt.byte_ready  = ready;
          out_data_nxt.image_done  = (phase_r == PH_DONE);
          out_data_nxt.error_code  = rerr_r;
          out_data_nxt.bad_codes   = bad_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (stk_we) begin
      sp_nxt = sp_r + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;    phase_r <= PH_WAIT;   sp_r <= 13'd0;
      buf_r <= 24'd0;       bits_r <= 5'd0;       cw_r <= 4'd0;
      ns_r <= 13'd0;        lim_r <= 13'd0;       prev_r <= 12'd0;
      first_r <= 8'd0;      sub_r <= 8'd0;        col_r <= 13'd320;
      xsc_r <= 8'd0;        ysc_r <= 8'd0;        bad_r <= 16'd0;
      root_r <= 4'd2;       aclr_r <= 1'b0;       guard_r <= 13'd0;
      lw_r <= 13'd320;      xskip_r <= 8'd0;      yskip_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt; sp_r <= sp_nxt;
      buf_r <= buf_nxt;     bits_r <= bits_nxt;   cw_r <= cw_nxt;
      ns_r <= ns_nxt;       lim_r <= lim_nxt;     prev_r <= prev_nxt;
      first_r <= first_nxt; sub_r <= sub_nxt;     col_r <= col_nxt;
      xsc_r <= xsc_nxt;     ysc_r <= ysc_nxt;     bad_r <= bad_nxt;
      root_r <= root_nxt;   aclr_r <= aclr_nxt;   guard_r <= guard_nxt;
      lw_r <= lw_nxt;       xskip_r <= xskip_nxt; yskip_r <= yskip_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    c_r <= c_nxt;
    rv_r <= rv_nxt;
    rpix_r <= rpix_nxt;
    rend_r <= rend_nxt;
    rerr_r <= rerr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### sv/gld_checker.sv
// gld_checker: port-level assertions for gif_lzw_decoder_core, bound to the top
// depends on gld_pkg
module gld_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input gld_pkg::out_item_t out_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_done_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.image_done |-> !out_data.byte_ready)
    else $error("finished image still asks for bytes");

  a_pixel_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pixel_valid |-> out_data.error_code == gld_pkg::ERR_NONE)
    else $error("pixel beat carries an error");

endmodule

bind gif_lzw_decoder_core gld_checker u_gld_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
